// ===== design/bfe_pkg.sv =====
// Shared widths, codes and defaults for the bit field extractor.
`timescale 1ns / 1ps
`default_nettype none
package bfe_pkg;

  localparam int STORE_BYTES_DEF = 4096;

  localparam int BYTE_ADDR_W  = 12;
  localparam int BYTE_W       = 8;
  localparam int BIT_ADDR_W   = 15;
  localparam int BIT_COUNT_W  = 7;
  localparam int WIDTH_CODE_W = 2;
  localparam int FIELD_W      = 64;
  localparam int VALID_LEN_W  = 13;

  // field spans at most nine bytes
  localparam int ACC_W = 72;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [WIDTH_CODE_W-1:0] RW_8  = 2'd0;
  localparam logic [WIDTH_CODE_W-1:0] RW_16 = 2'd1;
  localparam logic [WIDTH_CODE_W-1:0] RW_32 = 2'd2;
  localparam logic [WIDTH_CODE_W-1:0] RW_64 = 2'd3;

endpackage
`default_nettype wire

// ===== design/bfe_ifs.sv =====
// Channel interfaces of the bit field extractor: request in, result out, config write.
`timescale 1ns / 1ps
`default_nettype none
interface bfe_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [bfe_pkg::BYTE_ADDR_W-1:0]    byte_address;
  logic [bfe_pkg::BYTE_W-1:0]         write_byte;
  logic [bfe_pkg::BIT_ADDR_W-1:0]     bit_address;
  logic [bfe_pkg::BIT_COUNT_W-1:0]    bit_count;
  logic                               reversed;
  logic [bfe_pkg::WIDTH_CODE_W-1:0]   result_width;

  modport source (output valid, cmd, byte_address, write_byte, bit_address, bit_count,
                  reversed, result_width, input ready);
  modport sink   (input valid, cmd, byte_address, write_byte, bit_address, bit_count,
                  reversed, result_width, output ready);
endinterface

interface bfe_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfe_pkg::FIELD_W-1:0]    field_value;
  logic                           range_error;

  modport source (output valid, field_value, range_error, input ready);
  modport sink   (input valid, field_value, range_error, output ready);
endinterface

interface bfe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bfe_pkg::VALID_LEN_W-1:0]    valid_bytes;

  modport source (output valid, valid_bytes, input ready);
  modport sink   (input valid, valid_bytes, output ready);
endinterface
`default_nettype wire

// ===== design/bit_field_extractor.sv =====
// Bit field extractor: byte store with MSB-first bit field reads, optionally bit-reversed.
//
// Channels: in_ch takes requests (write one byte, or read a bit field),
// out_ch returns one result per request, cfg_ch writes valid_bytes at any
// cycle (always ready); write it only while no request is in flight.
// All transfers happen on a rising edge with valid and ready both high.
// A write request goes from accept to ST_DONE and then to the output register.
// A read request passes ST_CHECK, ST_READ for each of the N bytes the field
// spans (1 to 9), ST_DRAIN, ST_ALIGN and ST_DONE: the single-port byte
// memory delivers one byte per cycle. Zero-length and failed reads go from
// ST_CHECK straight to ST_DONE. One request is in work at a time;
// in_ch.ready is high only when idle.
// A finished result sits in the output register; the next request is
// accepted while it waits, and a result stalls in the last step only if the
// output register is still full.
// Reset (rst_n low, synchronous) clears control state and valid_bytes; the
// byte store is not cleared and reads of unwritten bytes are undefined.
`timescale 1ns / 1ps
`default_nettype none
module bit_field_extractor #(
  parameter int STORE_BYTES = bfe_pkg::STORE_BYTES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  bfe_in_if.sink     in_ch,
  bfe_out_if.source  out_ch,
  bfe_cfg_if.sink    cfg_ch
);

  localparam int AW   = $clog2(STORE_BYTES);
  localparam int LimW = ($clog2(STORE_BYTES + 1) > bfe_pkg::VALID_LEN_W) ?
                        $clog2(STORE_BYTES + 1) : bfe_pkg::VALID_LEN_W;
  localparam int FW   = bfe_pkg::FIELD_W;
  localparam int IW   = bfe_pkg::VALID_LEN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_DRAIN,
    ST_ALIGN,
    ST_DONE
  } state_t;

  state_t state_r;

  logic [bfe_pkg::BYTE_W-1:0] mem [STORE_BYTES];
  logic [bfe_pkg::BYTE_W-1:0] mem_rdata_r;

  logic [IW-1:0]                       valid_bytes_r;
  logic [bfe_pkg::BIT_ADDR_W-1:0]      bitaddr_r;
  logic [bfe_pkg::BIT_COUNT_W-1:0]     cnt_r;
  logic                                rev_r;
  logic [bfe_pkg::WIDTH_CODE_W-1:0]    rw_r;
  logic [IW-1:0]                       idx_r;
  logic [IW-1:0]                       last_r;
  logic [2:0]                          drop_r;
  logic                                rd_pend_r;
  logic [bfe_pkg::ACC_W-1:0]           acc_r;
  logic [FW-1:0]                       fld_r;
  logic                                zero_r;
  logic                                err_r;
  logic                                out_valid_r;
  logic [FW-1:0]                       out_value_r;
  logic                                out_err_r;

  logic                                in_acc;
  logic                                wr_ok;
  logic                                mem_re;
  logic [15:0]                         end_bit;
  logic [LimW-1:0]                     lim;
  logic                                chk_bad;
  logic [FW-1:0]                       cmask;
  logic [FW-1:0]                       wmask;
  logic [FW-1:0]                       fld_rev;
  logic [FW-1:0]                       res_val;
  logic                                out_free;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign wr_ok        = LimW'(in_ch.byte_address) < LimW'(STORE_BYTES);
  assign mem_re       = (state_r == ST_READ);
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.field_value = out_value_r;
  assign out_ch.range_error = out_err_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == bfe_pkg::CMD_WRITE && wr_ok) begin
      mem[AW'(in_ch.byte_address)] <= in_ch.write_byte;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[AW'(idx_r)];
    end
  end

  always_comb begin
    end_bit = 16'(bitaddr_r) + 16'(cnt_r) - 16'd1;
    lim = (LimW'(valid_bytes_r) < LimW'(STORE_BYTES)) ?
          LimW'(valid_bytes_r) : LimW'(STORE_BYTES);
    chk_bad = (cnt_r > 7'd64) ||
              (rev_r && rw_r == bfe_pkg::RW_8 && cnt_r > 7'd8) ||
              (cnt_r != '0 && LimW'(end_bit[15:3]) >= lim);
    cmask = (cnt_r == 7'd64) ? {FW{1'b1}} : ((64'd1 << cnt_r[5:0]) - 64'd1);
  end

  always_comb begin
    for (int i = 0; i < FW; i++) begin
      fld_rev[i] = fld_r[FW-1-i];
    end
    case (rw_r)
      bfe_pkg::RW_8:  wmask = 64'h0000_0000_0000_00FF;
      bfe_pkg::RW_16: wmask = 64'h0000_0000_0000_FFFF;
      bfe_pkg::RW_32: wmask = 64'h0000_0000_FFFF_FFFF;
      default:        wmask = {FW{1'b1}};
    endcase
    if (zero_r) begin
      res_val = '0;
    end else if (!rev_r) begin
      res_val = fld_r & wmask;
    end else begin
      case (rw_r)
        bfe_pkg::RW_8:  res_val = fld_rev >> (7'd64 - cnt_r);
        bfe_pkg::RW_16: res_val = fld_rev >> 48;
        bfe_pkg::RW_32: res_val = fld_rev >> 32;
        default:        res_val = fld_rev;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_bytes_r <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        valid_bytes_r <= cfg_ch.valid_bytes;
      end
      rd_pend_r <= mem_re;
      if (rd_pend_r) begin
        acc_r <= {acc_r[bfe_pkg::ACC_W-bfe_pkg::BYTE_W-1:0], mem_rdata_r};
      end
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            bitaddr_r <= in_ch.bit_address;
            cnt_r     <= in_ch.bit_count;
            rev_r     <= in_ch.reversed;
            rw_r      <= in_ch.result_width;
            if (in_ch.cmd == bfe_pkg::CMD_WRITE) begin
              zero_r  <= 1'b1;
              err_r   <= !wr_ok;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          idx_r  <= IW'(bitaddr_r[bfe_pkg::BIT_ADDR_W-1:3]);
          last_r <= end_bit[15:3];
          drop_r <= ~end_bit[2:0];
          acc_r  <= '0;
          err_r  <= chk_bad;
          if (chk_bad || cnt_r == '0) begin
            zero_r  <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            zero_r  <= 1'b0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          idx_r <= idx_r + IW'(1);
          if (idx_r == last_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_ALIGN;
        end
        ST_ALIGN: begin
          fld_r   <= FW'(acc_r >> drop_r) & cmask;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_val;
            out_err_r   <= err_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.range_error |-> out_ch.field_value == '0)
    else $error("error result with nonzero field");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.cmd == bfe_pkg::CMD_WRITE |=> state_r == ST_DONE && zero_r)
    else $error("write request did not go straight to result");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> idx_r <= last_r && LimW'(idx_r) < LimW'(STORE_BYTES))
    else $error("byte read beyond field or store");

  a_narrow_rev: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ALIGN && rev_r && rw_r == bfe_pkg::RW_8 |-> cnt_r <= 7'd8)
    else $error("reversed narrow read with oversized count");

endmodule
`default_nettype wire
